/* design/prr_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// prr_pkg: shared types and constants for the pixel row run unit
// Payload structs of the pixel and rectangle channels, register codes and
// the configuration bundle handed from the register file to both halves.
// ============================================================================
package prr_pkg;

    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;

    localparam int NM_W       = 42;
    localparam int SCALE_W    = 30;
    localparam int DIM_W      = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 30;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_KEYING = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_X_NM   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y_NM   = 3'd4;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } pixel_t;

    typedef struct packed {
        logic [NM_W-1:0] left_nm;
        logic [NM_W-1:0] top_nm;
        logic [NM_W-1:0] right_nm;
        logic [NM_W-1:0] bottom_nm;
        logic [7:0]      run_red;
        logic [7:0]      run_green;
        logic [7:0]      run_blue;
        logic            last;
    } rect_t;

    typedef struct packed {
        logic [DIM_W-1:0]   image_width;
        logic [DIM_W-1:0]   image_height;
        logic               alpha_keying;
        logic [SCALE_W-1:0] scale_x_nm;
        logic [SCALE_W-1:0] scale_y_nm;
    } cfg_t;

endpackage

/* design/prr_front.sv */
`timescale 1ns / 1ps
// ============================================================================
// prr_front: run tracker
// Accepts pixels, follows the open run and the row/column position, and
// pushes one command per pixel that closes one or two runs.
// ============================================================================
module prr_front
    import prr_pkg::*;
#(
    parameter int  MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int  MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int  CW         = 12,
    parameter int  RW         = 12,
    parameter type cmd_t      = logic
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  cfg_t   cfg,
    input  logic   pix_valid,
    output logic   pix_stall,
    input  pixel_t pix,
    input  logic   q_full,
    output logic   push,
    output cmd_t   cmd
);

    logic          run_open_reg, run_open_next;
    logic [23:0]   colour_reg, colour_next;
    logic [CW-1:0] start_reg, start_next;
    logic [CW-1:0] column_reg, column_next;
    logic [RW-1:0] row_reg, row_next;

    logic [31:0]   w_eff, h_eff;
    logic [CW-1:0] col_last;
    logic [RW-1:0] row_last;
    logic          accept;
    logic [23:0]   colour_in;
    logic          transparent;
    logic          close_a, keep_open, start_new, open_mid, end_of_row, close_b;
    logic [CW-1:0] mid_start;
    logic [23:0]   mid_colour;

    always_comb
    begin
        if (cfg.image_width == '0)
            w_eff = 32'd1;
        else if (32'(cfg.image_width) > 32'(MAX_WIDTH))
            w_eff = 32'(MAX_WIDTH);
        else
            w_eff = 32'(cfg.image_width);
        if (cfg.image_height == '0)
            h_eff = 32'd1;
        else if (32'(cfg.image_height) > 32'(MAX_HEIGHT))
            h_eff = 32'(MAX_HEIGHT);
        else
            h_eff = 32'(cfg.image_height);
    end

    assign col_last = CW'(w_eff - 32'd1);
    assign row_last = RW'(h_eff - 32'd1);

    assign pix_stall = q_full;
    assign accept    = pix_valid && !q_full;

    assign colour_in   = {pix.red, pix.green, pix.blue};
    assign transparent = cfg.alpha_keying && (pix.alpha == 8'd0);

    // first close: open run ends on a colour change or a transparent pixel
    assign close_a    = run_open_reg && (transparent || (colour_in != colour_reg));
    assign keep_open  = run_open_reg && !close_a;
    assign start_new  = !transparent && !keep_open;
    assign open_mid   = keep_open || start_new;
    assign mid_start  = start_new ? column_reg : start_reg;
    assign mid_colour = start_new ? colour_in : colour_reg;
    assign end_of_row = column_reg >= col_last;
    // second close: whatever is open at the last column
    assign close_b    = end_of_row && open_mid;

    always_comb
    begin
        cmd         = '0;
        cmd.row     = row_reg;
        cmd.has_a   = close_a;
        cmd.a.start = start_reg;
        cmd.a.stop  = {1'b0, column_reg};
        cmd.a.colour = colour_reg;
        cmd.has_b   = close_b;
        cmd.b.start = mid_start;
        cmd.b.stop  = {1'b0, column_reg} + (CW+1)'(1);
        cmd.b.colour = mid_colour;
    end

    assign push = accept && (close_a || close_b);

    always_comb
    begin
        run_open_next = run_open_reg;
        colour_next   = colour_reg;
        start_next    = start_reg;
        column_next   = column_reg;
        row_next      = row_reg;
        if (accept)
        begin
            run_open_next = open_mid && !end_of_row;
            colour_next   = mid_colour;
            start_next    = mid_start;
            if (end_of_row)
            begin
                column_next = '0;
                row_next    = (row_reg >= row_last) ? '0 : row_reg + RW'(1);
            end
            else
            begin
                column_next = column_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_open_reg <= 1'b0;
            colour_reg   <= '0;
            start_reg    <= '0;
            column_reg   <= '0;
            row_reg      <= '0;
        end
        else
        begin
            run_open_reg <= run_open_next;
            colour_reg   <= colour_next;
            start_reg    <= start_next;
            column_reg   <= column_next;
            row_reg      <= row_next;
        end
    end

endmodule

/* design/prr_queue.sv */
`timescale 1ns / 1ps
// ============================================================================
// prr_queue: command queue
// Small first-in first-out buffer between the run tracker and the
// rectangle builder; depth is a power of two.
// ============================================================================
module prr_queue
    import prr_pkg::*;
#(
    parameter int  DEPTH = 4,
    parameter type cmd_t = logic
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t head,
    output logic full,
    output logic empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int NW = $clog2(DEPTH + 1);

    cmd_t          slots_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign full    = count_reg == NW'(DEPTH);
    assign empty   = count_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + PW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + NW'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - NW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slots_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* design/prr_back.sv */
`timescale 1ns / 1ps
// ============================================================================
// prr_back: rectangle builder
// Takes one closed run per cycle from the queue head while rect_stall is low,
// scales the corners to nanometres and holds the result in the output register.
// ============================================================================
module prr_back
    import prr_pkg::*;
#(
    parameter int  CW    = 12,
    parameter int  RW    = 12,
    parameter type cmd_t = logic
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  cfg_t  cfg,
    input  cmd_t  head,
    input  logic  q_empty,
    output logic  pop,
    output logic  rect_valid,
    input  logic  rect_stall,
    output rect_t rect
);

    // operand stage
    logic          op_valid_reg, op_valid_next;
    logic          second_reg, second_next;
    logic [CW-1:0] op_start_reg;
    logic [CW:0]   op_stop_reg;
    logic [RW-1:0] op_row_reg;
    logic [RW:0]   op_row1_reg;
    logic [23:0]   op_colour_reg;
    logic          op_last_reg;

    // output stage
    logic          out_valid_reg;
    rect_t         out_reg;

    logic          adv_out, adv_op, take;
    logic          use_b;
    logic [CW-1:0] sel_start;
    logic [CW:0]   sel_stop;
    logic [23:0]   sel_colour;
    logic          sel_last;

    logic [CW+SCALE_W-1:0] left_p;
    logic [CW+SCALE_W:0]   right_p;
    logic [RW+SCALE_W-1:0] top_p;
    logic [RW+SCALE_W:0]   bottom_p;

    assign adv_out = !out_valid_reg || !rect_stall;
    assign adv_op  = !op_valid_reg || adv_out;
    assign take    = adv_op && !q_empty;

    // second span of a two-run command goes out after the first
    assign use_b      = second_reg || !head.has_a;
    assign sel_start  = use_b ? head.b.start : head.a.start;
    assign sel_stop   = use_b ? head.b.stop : head.a.stop;
    assign sel_colour = use_b ? head.b.colour : head.a.colour;
    assign sel_last   = use_b || !head.has_b;
    assign pop        = take && sel_last;

    always_comb
    begin
        second_next = second_reg;
        if (take)
            second_next = !sel_last;
        op_valid_next = op_valid_reg;
        if (adv_op)
            op_valid_next = !q_empty;
    end

    assign left_p   = (CW+SCALE_W)'(op_start_reg) * (CW+SCALE_W)'(cfg.scale_x_nm);
    assign right_p  = (CW+SCALE_W+1)'(op_stop_reg) * (CW+SCALE_W+1)'(cfg.scale_x_nm);
    assign top_p    = (RW+SCALE_W)'(op_row_reg) * (RW+SCALE_W)'(cfg.scale_y_nm);
    assign bottom_p = (RW+SCALE_W+1)'(op_row1_reg) * (RW+SCALE_W+1)'(cfg.scale_y_nm);

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            op_start_reg  <= sel_start;
            op_stop_reg   <= sel_stop;
            op_row_reg    <= head.row;
            op_row1_reg   <= {1'b0, head.row} + (RW+1)'(1);
            op_colour_reg <= sel_colour;
            op_last_reg   <= sel_last;
        end
        if (adv_out && op_valid_reg)
        begin
            out_reg.left_nm   <= NM_W'(left_p);
            out_reg.top_nm    <= NM_W'(top_p);
            out_reg.right_nm  <= NM_W'(right_p);
            out_reg.bottom_nm <= NM_W'(bottom_p);
            out_reg.run_red   <= op_colour_reg[23:16];
            out_reg.run_green <= op_colour_reg[15:8];
            out_reg.run_blue  <= op_colour_reg[7:0];
            out_reg.last      <= op_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_valid_reg  <= 1'b0;
            second_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            op_valid_reg <= op_valid_next;
            second_reg   <= second_next;
            if (adv_out)
                out_valid_reg <= op_valid_reg;
        end
    end

    assign rect_valid = out_valid_reg;
    assign rect       = out_reg;

endmodule

/* design/pixel_row_run_to_rectangles_unit.sv */
`timescale 1ns / 1ps
// ============================================================================
// pixel_row_run_to_rectangles_unit: RGB run-length encoder to rectangles
// Groups each raster row of RGBA pixels into runs of equal RGB and reports
// every closed run as a rectangle scaled to nanometres.
// ============================================================================
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+------------------------------
//  pix      | in        | pix_valid/pix_stall  | pixel_t: red green blue alpha
//  rect     | out       | rect_valid/rect_stall| rect_t: corners, colour, last
//  cfg      | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
//  One pixel is accepted per clock while pix_stall is low. A pixel that
//  closes two runs (colour change on the last column) needs two rect
//  transfers, so the output side sets the sustained rate: one rectangle per
//  clock while rect_stall is low. After a pix transfer the command passes
//  through the queue, then the operand register, then the multiplier and
//  output register, whose valid flag drives rect_valid.
//  A four-entry command queue lets the rect side stall without stalling
//  pix at once; pix_stall rises only when that queue is full.
//  Reset (rst_n low, asynchronous) closes any open run, zeroes the row and
//  column, empties the queue and loads width 1, height 1, keying off,
//  both scales 1. No clearing pass is needed.
//
module pixel_row_run_to_rectangles_unit
    import prr_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pix_valid,
    output logic                  pix_stall,
    input  pixel_t                pix,
    output logic                  rect_valid,
    input  logic                  rect_stall,
    output rect_t                 rect,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // column holds 0..MAX_WIDTH-1, row 0..MAX_HEIGHT-1
    localparam int CW          = $clog2(MAX_WIDTH);
    localparam int RW          = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [CW-1:0] start;
        logic [CW:0]   stop;
        logic [23:0]   colour;
    } span_t;

    // one pixel's worth of closed runs
    typedef struct packed {
        logic [RW-1:0] row;
        logic          has_a;
        span_t         a;
        logic          has_b;
        span_t         b;
    } run_cmd_t;

    cfg_t     cfg_reg, cfg_next;
    logic     push, pop, q_full, q_empty;
    run_cmd_t push_cmd, head;

    // register file: take a transfer every cycle, drop unknown indexes
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  cfg_next.image_width  = cfg_data[DIM_W-1:0];
                REG_IMAGE_HEIGHT: cfg_next.image_height = cfg_data[DIM_W-1:0];
                REG_ALPHA_KEYING: cfg_next.alpha_keying = cfg_data[0];
                REG_SCALE_X_NM:   cfg_next.scale_x_nm   = cfg_data[SCALE_W-1:0];
                REG_SCALE_Y_NM:   cfg_next.scale_y_nm   = cfg_data[SCALE_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_width  <= DIM_W'(1);
            cfg_reg.image_height <= DIM_W'(1);
            cfg_reg.alpha_keying <= 1'b0;
            cfg_reg.scale_x_nm   <= SCALE_W'(1);
            cfg_reg.scale_y_nm   <= SCALE_W'(1);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // front: follow runs, emit closing commands
    prr_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .CW         (CW),
        .RW         (RW),
        .cmd_t      (run_cmd_t)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix       (pix),
        .q_full    (q_full),
        .push      (push),
        .cmd       (push_cmd)
    );

    // hold commands while the rect side stalls
    prr_queue #(
        .DEPTH (QUEUE_DEPTH),
        .cmd_t (run_cmd_t)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .full     (q_full),
        .empty    (q_empty)
    );

    // back: scale corners, one rectangle per clock while rect_stall is low
    prr_back #(
        .CW    (CW),
        .RW    (RW),
        .cmd_t (run_cmd_t)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head       (head),
        .q_empty    (q_empty),
        .pop        (pop),
        .rect_valid (rect_valid),
        .rect_stall (rect_stall),
        .rect       (rect)
    );

endmodule
